@@ sv/lpp_pkg.sv @@
// ----------------------------------------------------------------------------
// LED pattern player package
// Shared constants, payload types and control structs for the player.
// ----------------------------------------------------------------------------
package lpp_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int FRAME_BITS  = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

    // Configuration register widths and the widest of them.
    localparam int SEQ_LEN_W = 9;
    localparam int REPEAT_W  = 8;
    localparam int HOLD_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd3;

    // Direction modes.
    localparam logic [MODE_W-1:0] MODE_FWD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BWD      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FWD_BWD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BWD_FWD  = 2'd3;

    // Input transaction kinds.
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    // Input transaction payload.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_address;
        logic [15:0] frame_word;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic [15:0] frame;
        logic        playing;
        logic        finished;
    } t_out_item;

    // Result flags produced by the control logic for one transaction.
    typedef struct packed {
        logic show;
        logic playing;
        logic finished;
    } t_step;

    // Frame table access request.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [FRAME_BITS-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

    // Description of one playback phase.
    typedef struct packed {
        logic              ok;
        logic              fwd;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_phase_info;

endpackage

@@ sv/lpp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED pattern player control
// Holds the configuration registers and the playback state, and turns each
// accepted transaction into a frame table request and its result flags.
// ----------------------------------------------------------------------------
module lpp_ctrl
    import lpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_in_item             i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_step                o_step,
    output t_mem_req             o_mem
);

    localparam int CMP_W = (LEN_W > SEQ_LEN_W) ? LEN_W : SEQ_LEN_W;

    // Configuration registers.
    logic [SEQ_LEN_W-1:0] r_seq_len;
    logic [REPEAT_W-1:0]  r_repeat;
    logic [HOLD_W-1:0]    r_hold;
    logic [MODE_W-1:0]    r_mode;

    // Playback state.
    logic [ADDR_W-1:0]   r_position, n_position;
    logic                r_phase, n_phase;
    logic [REPEAT_W-1:0] r_repeats_done, n_repeats_done;
    logic [HOLD_W-1:0]   r_hold_left, n_hold_left;
    logic                r_active, n_active;

    logic [LEN_W-1:0]  eff_len;
    logic [HOLD_W-1:0] eff_hold;
    t_phase_info       pi0, pi1, pi_cur;
    logic              show, fin;
    logic [HOLD_W-1:0] hold_dec;
    logic [REPEAT_W-1:0] rep_inc;

    // Shape of phase p for the current mode and effective length.
    function automatic t_phase_info phase_info(input logic p, input logic [MODE_W-1:0] m,
                                               input logic [LEN_W-1:0] n);
        t_phase_info res;
        logic        f;
        res = '0;
        if (!p) begin
            f      = (m == MODE_FWD) || (m == MODE_FWD_BWD);
            res.ok = 1'b1;
        end else begin
            f      = (m == MODE_BWD_FWD);
            res.ok = (m == MODE_FWD_BWD) || (m == MODE_BWD_FWD);
        end
        res.fwd = f;
        if (f) begin
            res.first = '0;
            res.last  = ADDR_W'(n - LEN_W'(1));
        end else begin
            case (m)
                MODE_BWD: begin
                    res.first = ADDR_W'(n - LEN_W'(1));
                    res.last  = '0;
                end
                MODE_FWD_BWD: begin
                    res.ok    = res.ok && (n >= LEN_W'(3));
                    res.first = ADDR_W'(n - LEN_W'(2));
                    res.last  = ADDR_W'(1);
                end
                MODE_BWD_FWD: begin
                    res.ok    = res.ok && (n >= LEN_W'(2));
                    res.first = ADDR_W'(n - LEN_W'(1));
                    res.last  = ADDR_W'(1);
                end
                default: begin
                    res.ok = 1'b0;
                end
            endcase
        end
        return res;
    endfunction

    // Effective length and hold time after clamping.
    always_comb begin
        if (r_seq_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (CMP_W'(r_seq_len) > CMP_W'(TABLE_DEPTH)) begin
            eff_len = LEN_W'(TABLE_DEPTH);
        end else begin
            eff_len = LEN_W'(r_seq_len);
        end
        eff_hold = (r_hold == '0) ? HOLD_W'(1) : r_hold;
    end

    assign pi0    = phase_info(1'b0, r_mode, eff_len);
    assign pi1    = phase_info(1'b1, r_mode, eff_len);
    assign pi_cur = r_phase ? pi1 : pi0;
    assign hold_dec = (r_hold_left != '0) ? r_hold_left - HOLD_W'(1) : '0;
    assign rep_inc  = r_repeats_done + REPEAT_W'(1);

    // Next playback state for the transaction being accepted.
    always_comb begin
        n_position     = r_position;
        n_phase        = r_phase;
        n_repeats_done = r_repeats_done;
        n_hold_left    = r_hold_left;
        n_active       = r_active;
        show           = 1'b0;
        fin            = 1'b0;
        case (i_item.kind)
            KIND_START: begin
                n_repeats_done = '0;
                if (r_repeat == '0 || !(pi0.ok || pi1.ok)) begin
                    n_active = 1'b0;
                    fin      = 1'b1;
                end else begin
                    n_active   = 1'b1;
                    show       = 1'b1;
                    n_phase    = !pi0.ok;
                    n_position = pi0.ok ? pi0.first : pi1.first;
                end
            end
            KIND_TICK: begin
                if (r_active) begin
                    n_hold_left = hold_dec;
                    if (hold_dec == '0) begin
                        if (pi_cur.ok && pi_cur.fwd && r_position < pi_cur.last) begin
                            n_position = r_position + ADDR_W'(1);
                            show       = 1'b1;
                        end else if (pi_cur.ok && !pi_cur.fwd
                                     && r_position > pi_cur.last) begin
                            n_position = r_position - ADDR_W'(1);
                            show       = 1'b1;
                        end else if (!r_phase && pi1.ok) begin
                            n_phase    = 1'b1;
                            n_position = pi1.first;
                            show       = 1'b1;
                        end else begin
                            // End of one repetition of the whole sequence.
                            n_repeats_done = rep_inc;
                            if (rep_inc >= r_repeat || !(pi0.ok || pi1.ok)) begin
                                n_active = 1'b0;
                                fin      = 1'b1;
                            end else begin
                                n_phase    = !pi0.ok;
                                n_position = pi0.ok ? pi0.first : pi1.first;
                                show       = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_STOP: begin
                n_active = 1'b0;
            end
            default: begin
            end
        endcase
        if (show) begin
            n_hold_left = eff_hold;
        end
    end

    // Frame table requests: loads write, a newly shown frame is read.
    always_comb begin
        o_mem.we    = i_accept && (i_item.kind == KIND_LOAD)
                      && (int'(i_item.frame_address) < TABLE_DEPTH);
        o_mem.waddr = ADDR_W'(i_item.frame_address);
        o_mem.wdata = FRAME_BITS'(i_item.frame_word);
        o_mem.re    = i_accept && show;
        o_mem.raddr = n_position;
    end

    assign o_step.show     = show;
    assign o_step.playing  = n_active;
    assign o_step.finished = fin;

    // Configuration writes and playback state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len      <= SEQ_LEN_W'(1);
            r_repeat       <= REPEAT_W'(1);
            r_hold         <= HOLD_W'(1);
            r_mode         <= MODE_FWD;
            r_position     <= '0;
            r_phase        <= 1'b0;
            r_repeats_done <= '0;
            r_hold_left    <= '0;
            r_active       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEQ_LEN: r_seq_len <= i_cfg_data[SEQ_LEN_W-1:0];
                    CFG_REPEAT:  r_repeat  <= i_cfg_data[REPEAT_W-1:0];
                    CFG_HOLD:    r_hold    <= i_cfg_data[HOLD_W-1:0];
                    CFG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_position     <= n_position;
                r_phase        <= n_phase;
                r_repeats_done <= n_repeats_done;
                r_hold_left    <= n_hold_left;
                r_active       <= n_active;
            end
        end
    end

endmodule

@@ sv/led_pattern_player.sv @@
// ----------------------------------------------------------------------------
// LED pattern player
// Plays a table of LED frames forward, backward or in ping-pong order, one
// frame per programmed number of tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (valid/ready) carry a kind: load writes one frame into
//   the table, start begins playback, tick stands for one millisecond and
//   stop ends playback. Every input transaction yields exactly one result
//   transaction (valid/ready) with the shown frame, the playing flag and a
//   finished pulse on the transaction that ends the last repetition or on a start that has nothing to play.
//   Configuration registers are written through a plain write port (enable,
//   index, data) while no transaction is in flight.
//   Throughput is one transaction per cycle while the receiver keeps up. A
//   result passes the read stage and then the output register: the edge that
//   accepts its input updates the control state and reads the frame table,
//   and the output register is loaded from the read stage once it is free.
//   When the receiver stalls, the read stage and the output register fill
//   and input ready drops; nothing is lost.
//   Reset clears playback state and loads register defaults (length 1,
//   one repetition, hold 1, forward). The frame table is not cleared; only
//   written entries may be played.
// ----------------------------------------------------------------------------
module led_pattern_player
    import lpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic                  accept;
    logic                  s1_move;
    t_step                 step;
    t_mem_req              mem;
    logic [FRAME_BITS-1:0] rdata;
    logic [FRAME_BITS-1:0] n_shown;

    logic                  r_s1_valid;
    t_step                 r_s1_step;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    logic [FRAME_BITS-1:0] r_shown;

    // Handshake: the read stage moves on when the output register frees up.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    lpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_step      (step),
        .o_mem       (mem)
    );

    lpp_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    // A transaction that shows a new frame takes it from the table read.
    assign n_shown = r_s1_step.show ? rdata : r_shown;

    // Read stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_step   <= '0;
            r_out_valid <= 1'b0;
            r_shown     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_step  <= step;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_shown     <= n_shown;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_item.frame    <= 16'(n_shown);
            r_out_item.playing  <= r_s1_step.playing;
            r_out_item.finished <= r_s1_step.finished;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ test/led_pattern_player_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED pattern player testbench
// Drives load, start, tick and stop transactions through the valid/ready
// input, programs the registers between phases and predicts every result
// transaction in a scoreboard that plays the frame table on its own. The
// sender works in random bursts and the receiver stalls on a rotating mask.
// ----------------------------------------------------------------------------
module led_pattern_player_tb;
    import lpp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_SLACK  = 4;

    // Tracks the played frame table and holds the expected result stream.
    class frame_scoreboard;
        logic [FRAME_BITS-1:0] frame_mem [TABLE_DEPTH];
        int                    pos;
        int                    ph;
        bit [REPEAT_W-1:0]     reps_done;
        bit [HOLD_W-1:0]       hold_left;
        bit                    running;
        bit [FRAME_BITS-1:0]   shown;
        bit [SEQ_LEN_W-1:0]    seq_len;
        bit [REPEAT_W-1:0]     reps_cfg;
        bit [HOLD_W-1:0]       hold_cfg;
        bit [MODE_W-1:0]       mode_cfg;
        t_out_item             expected_frames [$];
        int                    fail_count;

        function new();
            foreach (frame_mem[i]) frame_mem[i] = '0;
            pos = 0;
            ph = 0;
            reps_done = '0;
            hold_left = '0;
            running = 1'b0;
            shown = '0;
            seq_len = 9'd1;
            reps_cfg = 8'd1;
            hold_cfg = 16'd1;
            mode_cfg = MODE_FWD;
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SEQ_LEN: seq_len  = data[SEQ_LEN_W-1:0];
                CFG_REPEAT:  reps_cfg = data[REPEAT_W-1:0];
                CFG_HOLD:    hold_cfg = data[HOLD_W-1:0];
                CFG_MODE:    mode_cfg = data[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // A zero length plays one frame; lengths past the table are clipped.
        function int frames();
            int n;
            n = seq_len;
            if (n == 0) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            return n;
        endfunction

        // Span of one phase in the current mode; zero when it is absent or empty.
        function bit phase_span(int p, output bit fwd, output int first, output int last);
            int n;
            bit f;
            n = frames();
            if (p == 0) begin
                f = (mode_cfg == MODE_FWD || mode_cfg == MODE_FWD_BWD);
            end else begin
                if (mode_cfg == MODE_FWD || mode_cfg == MODE_BWD) return 1'b0;
                f = (mode_cfg == MODE_BWD_FWD);
            end
            if (f) begin
                fwd = 1'b1;
                first = 0;
                last = n - 1;
                return 1'b1;
            end
            fwd = 1'b0;
            if (mode_cfg == MODE_BWD) begin
                first = n - 1;
                last = 0;
                return 1'b1;
            end
            if (mode_cfg == MODE_FWD_BWD) begin
                if (n < 3) return 1'b0;
                first = n - 2;
                last = 1;
                return 1'b1;
            end
            if (n < 2) return 1'b0;
            first = n - 1;
            last = 1;
            return 1'b1;
        endfunction

        function bit enter_phase(int p);
            bit f;
            int a;
            int b;
            for (int q = p; q < 2; q++) begin
                if (phase_span(q, f, a, b)) begin
                    ph = q;
                    pos = a;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void show_pos();
            shown = frame_mem[pos];
            hold_left = (hold_cfg == 0) ? 16'd1 : hold_cfg;
        endfunction

        // Steps to the next frame; returns one when the last repetition ends.
        function bit next_frame();
            bit fwd;
            int first;
            int last;
            if (phase_span(ph, fwd, first, last)) begin
                if (fwd && pos < last) begin
                    pos++;
                    show_pos();
                    return 1'b0;
                end
                if (!fwd && pos > last) begin
                    pos--;
                    show_pos();
                    return 1'b0;
                end
            end
            if (ph == 0 && enter_phase(1)) begin
                show_pos();
                return 1'b0;
            end
            reps_done++;
            if (reps_done >= reps_cfg || !enter_phase(0)) begin
                running = 1'b0;
                return 1'b1;
            end
            show_pos();
            return 1'b0;
        endfunction

        // Applies one accepted input transaction and queues its result.
        function void predict_frame(t_in_item it);
            t_out_item e;
            bit fin;
            fin = 1'b0;
            case (it.kind)
                KIND_LOAD: frame_mem[it.frame_address] = it.frame_word;
                KIND_START: begin
                    reps_done = '0;
                    if (reps_cfg == 0 || !enter_phase(0)) begin
                        running = 1'b0;
                        fin = 1'b1;
                    end else begin
                        running = 1'b1;
                        show_pos();
                    end
                end
                KIND_TICK: begin
                    if (running) begin
                        if (hold_left > 0) hold_left--;
                        if (hold_left == 0) fin = next_frame();
                    end
                end
                default: running = 1'b0;
            endcase
            e.frame = shown;
            e.playing = running;
            e.finished = fin;
            expected_frames.push_back(e);
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_frame(t_out_item got);
            t_out_item exp_item;
            if (expected_frames.size() == 0) begin
                $error("unexpected result: frame %h playing %b finished %b",
                       got.frame, got.playing, got.finished);
                fail_count++;
                return;
            end
            exp_item = expected_frames.pop_front();
            if (got.frame !== exp_item.frame) begin
                $error("frame: expected %h, actual %h", exp_item.frame, got.frame);
                fail_count++;
            end
            if (got.playing !== exp_item.playing) begin
                $error("playing: expected %b, actual %b", exp_item.playing, got.playing);
                fail_count++;
            end
            if (got.finished !== exp_item.finished) begin
                $error("finished: expected %b, actual %b", exp_item.finished, got.finished);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    frame_scoreboard sb = new();
    bit              frame_written [TABLE_DEPTH];
    int              burst_left = 0;
    int              tx_gap_max = 2;
    logic [15:0]     rx_pattern = 16'hF3FF;
    logic [3:0]      rx_slot = '0;
    int unsigned     cycle_count = 0;

    led_pattern_player DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls wherever the rotating mask holds a zero.
    always @(posedge i_clk) begin
        rx_slot <= rx_slot + 1'b1;
        i_out_ready <= rx_pattern[rx_slot];
    end

    // Every accepted result transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_frame(o_out_item);
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_pattern_player: mismatch");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_kind k, logic [7:0] addr, logic [15:0] word);
        t_in_item it;
        it.kind = k;
        it.frame_address = addr;
        it.frame_word = word;
        return it;
    endfunction

    // Offers one transaction, with a random gap between bursts, and waits
    // until it is accepted.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.predict_frame(it);
        if (it.kind == KIND_LOAD) frame_written[it.frame_address] = 1'b1;
    endtask

    task automatic send_kind(input t_kind k);
        send_item(make_item(k, 8'($urandom), 16'($urandom)));
    endtask

    task automatic load_frame(input logic [7:0] addr, input logic [15:0] word);
        send_item(make_item(KIND_LOAD, addr, word));
    endtask

    // Loads every entry below n that was never written, so playback only
    // reads defined frames.
    task automatic cover_table(input int n);
        for (int i = 0; i < n; i++) begin
            if (!frame_written[i]) load_frame(8'(i), 16'($urandom));
        end
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Writes all four registers while no transaction is in flight. Bits
    // above each register's width carry junk that the block must drop.
    task automatic program_regs(input bit [8:0] len, input bit [7:0] rep,
                                input bit [15:0] hold, input bit [1:0] mode);
        settle();
        write_reg(CFG_SEQ_LEN, {7'($urandom), len});
        write_reg(CFG_REPEAT, {8'($urandom), rep});
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_MODE, {14'($urandom), mode});
        i_cfg_we <= 1'b0;
    endtask

    // Directed corner cases: idle commands, field extremes, restarts, live
    // register changes, zero repetitions and the longest hold.
    task automatic directed_checks();
        send_kind(KIND_TICK);
        send_kind(KIND_STOP);
        load_frame(8'd0, 16'hFFFF);
        load_frame(8'd255, 16'h0000);
        load_frame(8'd1, 16'hA5A5);
        load_frame(8'd2, 16'h5A5A);
        load_frame(8'd3, 16'h0001);
        send_kind(KIND_START);
        send_kind(KIND_TICK);

        // Ping-pong with zero hold; a load and a restart during playback.
        program_regs(9'd4, 8'd2, 16'd0, MODE_FWD_BWD);
        send_kind(KIND_START);
        repeat (3) send_kind(KIND_TICK);
        load_frame(8'd2, 16'h1234);
        send_kind(KIND_START);
        send_kind(KIND_TICK);

        // Shrink the length while the player is still running.
        program_regs(9'd2, 8'd2, 16'd0, MODE_FWD_BWD);
        repeat (3) send_kind(KIND_TICK);
        send_kind(KIND_STOP);

        // A zero length acts as one frame; zero repetitions end at once.
        program_regs(9'd0, 8'd0, 16'd1, MODE_BWD);
        send_kind(KIND_START);

        program_regs(9'd3, 8'd3, 16'd2, MODE_BWD_FWD);
        send_kind(KIND_START);
        repeat (4) send_kind(KIND_TICK);

        program_regs(9'd4, 8'd255, 16'd65535, MODE_BWD);
        send_kind(KIND_START);
        send_kind(KIND_TICK);
        send_kind(KIND_STOP);
    endtask

    // One random phase: new registers and idling, then a start followed by
    // mostly ticks, with loads, restarts and stops mixed in.
    task automatic play_phase(input int idx, input int n_items);
        bit [8:0]  len;
        bit [7:0]  rep;
        bit [15:0] hold;
        bit [1:0]  mode;
        int        r;
        int        n;

        r = $urandom_range(99);
        if (r < 10) len = 9'd0;
        else if (r < 55) len = 9'($urandom_range(1, 4));
        else if (r < 80) len = 9'($urandom_range(5, 16));
        else if (r < 88) len = 9'd256;
        else if (r < 94) len = 9'($urandom_range(257, 511));
        else len = 9'($urandom_range(17, 255));
        if (idx == 0) len = 9'd511;

        r = $urandom_range(99);
        if (r < 10) rep = 8'd0;
        else if (r < 50) rep = 8'd1;
        else if (r < 85) rep = 8'($urandom_range(2, 4));
        else if (r < 95) rep = 8'd255;
        else rep = 8'($urandom_range(5, 254));

        r = $urandom_range(99);
        if (r < 15) hold = 16'd0;
        else if (r < 55) hold = 16'd1;
        else if (r < 85) hold = 16'($urandom_range(2, 4));
        else if (r < 93) hold = 16'd65535;
        else hold = 16'($urandom_range(5, 300));

        mode = 2'($urandom_range(3));

        n = (len == 0) ? 1 : (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
        cover_table(n);
        program_regs(len, rep, hold, mode);

        // Idling for this phase, from none at all to long stalls.
        case ($urandom_range(3))
            0: tx_gap_max = 0;
            1: tx_gap_max = 0;
            2: tx_gap_max = 2;
            default: tx_gap_max = 6;
        endcase
        case ($urandom_range(4))
            0: rx_pattern <= 16'hFFFF;
            1: rx_pattern <= 16'($urandom) | 16'h0001;
            2: rx_pattern <= 16'h00FF;
            3: rx_pattern <= 16'h5555;
            default: rx_pattern <= 16'h0001;
        endcase

        send_kind(KIND_START);
        for (int i = 0; i < n_items; i++) begin
            // Now and then hold the sender back until the pipeline is empty.
            if (i == n_items / 2 && idx % 4 == 1) settle();
            r = $urandom_range(99);
            if (!sb.running && r < 30) send_kind(KIND_START);
            else if (r < 8) load_frame(8'($urandom), 16'($urandom));
            else if (r < 11) send_kind(KIND_START);
            else if (r < 14) send_kind(KIND_STOP);
            else send_kind(KIND_TICK);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_checks();
        for (int p = 0; p < 20; p++) play_phase(p, 45);
        settle();
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("led_pattern_player: match");
        end else begin
            $display("led_pattern_player: mismatch");
        end
        $finish;
    end

endmodule
